@@ hw/rtl/assert_macros.svh @@
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_ON(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/lrupr_pkg.sv @@
package lrupr_pkg;

  localparam int MAX_WAYS = 32;
  // page and capacity widths are fixed by the port fields
  localparam int PAGE_W = 16;
  localparam int CAP_W = 6;
  localparam int COUNT_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // what one cell hands to the next one down the chain
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              valid;
    logic              seen;
  } lrupr_link_t;

  // control from the top to every cell
  typedef struct packed {
    logic upd;
    logic clr;
  } lrupr_ctrl_t;

endpackage

@@ hw/rtl/lrupr_cell.sv @@
module lrupr_cell import lrupr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  lrupr_ctrl_t       ctrl,
  input  logic              lim,
  input  logic [PAGE_W-1:0] probe,
  input  lrupr_link_t       prev,
  output lrupr_link_t       link,
  output logic              match
);

  logic [PAGE_W-1:0] page;
  logic              valid;
  logic              shift;

  assign match = valid && (page == probe);
  // a cell moves down unless the hit lies in a more recent slot
  assign shift = ctrl.upd && lim && !prev.seen;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      page <= prev.page;
    end
  end

  assign link.page  = page;
  assign link.valid = valid;
  assign link.seen  = prev.seen || match;

endmodule

@@ hw/rtl/lru_page_replacement_top.sv @@
// LRU page cache, fully associative, built as a recency chain of cells.
// input channel: in_valid / in_stall with page; one beat is one reference.
// output channel: out_valid / out_stall with hit, evicted_valid,
//   evicted_page (zero when nothing left the cache) and miss_count.
// config channel: cfg_valid / cfg_ready with cfg_data, the capacity;
//   cfg_ready is always high. a write empties the cache and clears the
//   miss count; zero acts as one and values above the chain depth as the
//   chain depth. write it only while no result is pending.
// each reference gives exactly one result beat, in the cycle after it is
// taken, from the output register. every cell compares its page with the
// reference and shifts one slot in the same cycle, so a reference can be
// taken every cycle while no result beat is stalled.
// when the output register holds a beat that is stalled, in_stall is high
// and the chain does not move until that beat is taken.
// reset: capacity 16, cache empty, miss count zero, no result pending.
module lru_page_replacement_top import lrupr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PAGE_W-1:0]  page,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic               evicted_valid,
  output logic [PAGE_W-1:0]  evicted_page,
  output logic [COUNT_W-1:0] miss_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CAP_W-1:0]   cfg_data
);

  `include "assert_macros.svh"

  logic [CAP_W-1:0]   capacity;
  logic [CAP_W-1:0]   eff_cap;
  logic [COUNT_W-1:0] misses;
  logic [COUNT_W-1:0] misses_next;
  logic               accept;
  lrupr_ctrl_t        ctrl;
  lrupr_link_t        chain [MAX_WAYS+1];
  logic [MAX_WAYS-1:0] lim;
  logic [MAX_WAYS-1:0] slot_hit;
  logic [MAX_WAYS-1:0] valids;
  logic               hit_now;
  logic               full;
  logic [PAGE_W-1:0]  tail_page;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  assign ctrl.upd = accept;
  assign ctrl.clr = cfg_valid && cfg_ready;

  always_comb begin
    eff_cap = capacity;
    if (capacity == '0) begin
      eff_cap = CAP_W'(1);
    end else if (int'(capacity) > MAX_WAYS) begin
      eff_cap = CAP_W'(MAX_WAYS);
    end
  end

  // head of the chain is the reference itself
  assign chain[0].page  = page;
  assign chain[0].valid = 1'b1;
  assign chain[0].seen  = 1'b0;

  for (genvar i = 0; i < MAX_WAYS; i++) begin : g_cell
    assign lim[i]    = int'(eff_cap) > i;
    assign valids[i] = chain[i+1].valid;
    lrupr_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .lim   (lim[i]),
      .probe (page),
      .prev  (chain[i]),
      .link  (chain[i+1]),
      .match (slot_hit[i])
    );
  end

  assign hit_now = chain[MAX_WAYS].seen;

  // least recent slot is the last one the capacity allows
  always_comb begin
    full      = 1'b0;
    tail_page = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (int'(eff_cap) == i + 1) begin
        full      = chain[i+1].valid;
        tail_page = chain[i+1].page;
      end
    end
  end

  always_comb begin
    misses_next = misses;
    if (!hit_now && (misses != '1)) begin
      misses_next = misses + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      misses   <= '0;
    end else if (ctrl.clr) begin
      capacity <= cfg_data;
      misses   <= '0;
    end else if (accept) begin
      misses <= misses_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit           <= hit_now;
      evicted_valid <= !hit_now && full;
      evicted_page  <= (!hit_now && full) ? tail_page : '0;
      miss_count    <= misses_next;
    end
  end

  `ASSERT_ON(a_hit_no_evict, clk, rst, out_valid |-> !(hit && evicted_valid), "hit with eviction")
  `ASSERT_ON(a_evict_zero, clk, rst, (out_valid && !evicted_valid) |-> !(|evicted_page), "stray page")
  `ASSERT_ON(a_unique_match, clk, rst, $onehot0(slot_hit), "page held in two slots")
  `ASSERT_ON(a_valid_prefix, clk, rst, $onehot0(valids + MAX_WAYS'(1)), "valid slots not contiguous")
  `ASSERT_ON(a_miss_count, clk, rst, (accept && !hit_now && !ctrl.clr) |=> (misses != '0), "miss lost")

endmodule
